/* src/ccp_pkg.sv */
// Charset parser package: op, queue-head and register index types, kind codes,
// queue sizing. No dependencies.
package ccp_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned OffsetW = 31;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHARSET_OFFSET = 1'b0,
    REG_GLYPH_COUNT    = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_ISOADOBE   = 3'd0,
    KIND_EXPERT     = 3'd1,
    KIND_EXP_SUBSET = 3'd2,
    KIND_FORMAT0    = 3'd3,
    KIND_FORMAT1    = 3'd4,
    KIND_FORMAT2    = 3'd5,
    KIND_UNKNOWN    = 3'd6
  } kind_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

endpackage

/* src/ccp_if.sv */
// Channel interfaces of the charset parser: table items, results, config writes.
// Depends on ccp_pkg.
interface ccp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] byte_value;
  modport source (output valid, command, byte_value, input ready);
  modport sink (input valid, command, byte_value, output ready);
endinterface

interface ccp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        is_record;
  logic [15:0] first_name;
  logic [15:0] range_left;
  logic        last;
  modport source (output valid, kind, is_record, first_name, range_left, last, input ready);
  modport sink (input valid, kind, is_record, first_name, range_left, last, output ready);
endinterface

interface ccp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ccp_pkg::CfgIdxW-1:0] index;
  logic [ccp_pkg::OffsetW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/ccp_front.sv */
// Front end: accepts items, classifies them into start / byte ops, queues them.
// Depends on ccp_pkg and ccp_if.
module ccp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ccp_in_if.sink               in_i,
  output ccp_pkg::queue_head_t head_o,
  input  logic                 pop_i
);

  ccp_pkg::op_t                     mem_q [ccp_pkg::QueueDepth];
  logic [ccp_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [ccp_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ccp_pkg::QueueCntW-1:0]    cnt_q, cnt_d;
  logic                             push;
  logic                             pop;
  ccp_pkg::op_t                     new_op;

  assign in_i.ready = (cnt_q != ccp_pkg::QueueCntW'(ccp_pkg::QueueDepth));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    new_op.kind = in_i.command ? ccp_pkg::OP_BYTE : ccp_pkg::OP_START;
    new_op.data = in_i.byte_value;
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == ccp_pkg::QueuePtrW'(ccp_pkg::QueueDepth - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == ccp_pkg::QueuePtrW'(ccp_pkg::QueueDepth - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_op;
    end
  end

endmodule

/* src/ccp_back.sv */
// Back end: config registers, charset parse state machine, result register.
// Depends on ccp_pkg and ccp_if.
module ccp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ccp_cfg_if.sink              cfg_i,
  input  ccp_pkg::queue_head_t head_i,
  output logic                 pop_o,
  ccp_out_if.source            out_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FORMAT  = 2'd1,
    PH_RECORDS = 2'd2
  } phase_e;

  logic [ccp_pkg::OffsetW-1:0] offset_q;
  logic [ccp_pkg::CountW-1:0]  gcount_q;

  phase_e        phase_q, phase_d;
  logic [1:0]    fmt_q, fmt_d;
  logic [1:0]    pos_q, pos_d;
  logic [23:0]   asm_q, asm_d;
  logic [16:0]   covered_q, covered_d;
  logic [15:0]   names_q, names_d;

  logic          ovalid_q, ovalid_d;
  ccp_pkg::kind_e okind_q, okind_d;
  logic          orec_q, orec_d;
  logic [15:0]   ofirst_q, ofirst_d;
  logic [15:0]   oleft_q, oleft_d;
  logic          olast_q, olast_d;
  logic          emit;

  logic [16:0]   eff_count;
  logic [31:0]   acc;
  logic [1:0]    need_m1;
  logic [15:0]   rec_first;
  logic [15:0]   rec_left;
  logic [16:0]   cov_sum;
  logic [15:0]   names_dec;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      gcount_q <= ccp_pkg::CountW'(1);
    end else if (cfg_i.valid) begin
      unique case (ccp_pkg::reg_idx_e'(cfg_i.index))
        ccp_pkg::REG_CHARSET_OFFSET: offset_q <= cfg_i.data;
        ccp_pkg::REG_GLYPH_COUNT:    gcount_q <= cfg_i.data[ccp_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  assign pop_o = head_i.valid && (!ovalid_q || out_o.ready);

  assign eff_count = (gcount_q == '0) ? 17'd1 : {1'b0, gcount_q};
  assign acc       = {asm_q, head_i.op.data};
  assign names_dec = names_q - 16'd1;

  always_comb begin
    unique case (fmt_q)
      2'd0:    need_m1 = 2'd1;
      2'd1:    need_m1 = 2'd2;
      default: need_m1 = 2'd3;
    endcase
    unique case (fmt_q)
      2'd0: begin
        rec_first = acc[15:0];
        rec_left  = '0;
      end
      2'd1: begin
        rec_first = acc[23:8];
        rec_left  = {8'd0, acc[7:0]};
      end
      default: begin
        rec_first = acc[31:16];
        rec_left  = acc[15:0];
      end
    endcase
    cov_sum = covered_q + 17'd1 + {1'b0, rec_left};
  end

  always_comb begin
    phase_d   = phase_q;
    fmt_d     = fmt_q;
    pos_d     = pos_q;
    asm_d     = asm_q;
    covered_d = covered_q;
    names_d   = names_q;
    emit      = 1'b0;
    okind_d   = okind_q;
    orec_d    = 1'b0;
    ofirst_d  = '0;
    oleft_d   = '0;
    olast_d   = 1'b1;

    if (pop_o) begin
      if (head_i.op.kind == ccp_pkg::OP_START) begin
        pos_d     = '0;
        asm_d     = '0;
        covered_d = 17'd1;
        fmt_d     = '0;
        if (offset_q <= ccp_pkg::OffsetW'(2)) begin
          phase_d = PH_IDLE;
          names_d = '0;
          emit    = 1'b1;
          okind_d = ccp_pkg::kind_e'({1'b0, offset_q[1:0]});
        end else begin
          phase_d = PH_FORMAT;
          names_d = eff_count[15:0] - 16'd1;
        end
      end else begin
        unique case (phase_q)
          PH_FORMAT: begin
            if (head_i.op.data > 8'd2) begin
              phase_d = PH_IDLE;
              emit    = 1'b1;
              okind_d = ccp_pkg::KIND_UNKNOWN;
            end else begin
              fmt_d = head_i.op.data[1:0];
              pos_d = '0;
              asm_d = '0;
              if ((head_i.op.data == 8'd0) ? (names_q == '0) : (covered_q >= eff_count)) begin
                phase_d = PH_IDLE;
                emit    = 1'b1;
                okind_d = ccp_pkg::kind_e'(3'd3 + {1'b0, head_i.op.data[1:0]});
              end else begin
                phase_d = PH_RECORDS;
              end
            end
          end
          PH_RECORDS: begin
            if (pos_q < need_m1) begin
              asm_d = acc[23:0];
              pos_d = pos_q + 2'd1;
            end else begin
              pos_d    = '0;
              asm_d    = '0;
              emit     = 1'b1;
              okind_d  = ccp_pkg::kind_e'(3'd3 + {1'b0, fmt_q});
              orec_d   = 1'b1;
              ofirst_d = rec_first;
              oleft_d  = rec_left;
              if (fmt_q == 2'd0) begin
                names_d = names_dec;
                olast_d = (names_dec == '0);
              end else begin
                covered_d = cov_sum;
                olast_d   = (cov_sum >= eff_count);
              end
              if (olast_d) begin
                phase_d = PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
    end

    ovalid_d = emit || (ovalid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      fmt_q     <= '0;
      pos_q     <= '0;
      asm_q     <= '0;
      covered_q <= 17'd1;
      names_q   <= '0;
      ovalid_q  <= 1'b0;
      okind_q   <= ccp_pkg::KIND_ISOADOBE;
      orec_q    <= 1'b0;
      ofirst_q  <= '0;
      oleft_q   <= '0;
      olast_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      fmt_q     <= fmt_d;
      pos_q     <= pos_d;
      asm_q     <= asm_d;
      covered_q <= covered_d;
      names_q   <= names_d;
      ovalid_q  <= ovalid_d;
      if (emit) begin
        okind_q  <= okind_d;
        orec_q   <= orec_d;
        ofirst_q <= ofirst_d;
        oleft_q  <= oleft_d;
        olast_q  <= olast_d;
      end
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.kind       = okind_q;
  assign out_o.is_record  = orec_q;
  assign out_o.first_name = ofirst_q;
  assign out_o.range_left = oleft_q;
  assign out_o.last       = olast_q;

endmodule

/* src/cff_charset_parser.sv */
// Charset table parser, top level: front queue feeding the parse back end.
// Items are queued when accepted; any result is loaded into the result register
// when the back end pops its op. Throughput: one item per cycle while the queue
// has room; the back end retires one op per cycle while the result register
// is free or being taken. Reset: asynchronous, active low; config returns to
// offset 0, glyph count 1, parser idle, queue and result register empty.
module cff_charset_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccp_in_if.sink    in_i,
  ccp_cfg_if.sink   cfg_i,
  ccp_out_if.source out_o
);

  ccp_pkg::queue_head_t head;
  logic                 pop;

  ccp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  ccp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

/* bench/tb_cff_charset_parser.sv */
`timescale 1ns / 1ps
// Testbench for cff_charset_parser: directed and random charset tables, checked
// item by item against a charset tracker class. Depends on ccp_pkg and ccp_if.
module tb_cff_charset_parser;

  localparam int unsigned CycleLimit = 300000;

  typedef struct packed {
    ccp_pkg::kind_e kind;
    logic           is_record;
    logic [15:0]    first_name;
    logic [15:0]    range_left;
    logic           last;
  } charset_entry_t;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_FORMAT,
    PARSE_RECORDS
  } parse_phase_e;

  class charset_tracker;
    logic [30:0]    offset_reg;
    logic [15:0]    count_reg;
    parse_phase_e   phase;
    logic [1:0]     fmt;
    logic [1:0]     pos;
    logic [23:0]    acc_bytes;
    logic [16:0]    covered;
    logic [15:0]    names_left;
    charset_entry_t expected_entries[$];
    int unsigned    errors;

    function new();
      offset_reg = '0;
      count_reg  = 16'd1;
      phase      = PARSE_IDLE;
      fmt        = '0;
      pos        = '0;
      acc_bytes  = '0;
      covered    = 17'd1;
      names_left = '0;
      errors     = 0;
    endfunction

    function void write_reg(ccp_pkg::reg_idx_e idx, logic [30:0] value);
      if (idx == ccp_pkg::REG_CHARSET_OFFSET) begin
        offset_reg = value;
      end else begin
        count_reg = value[15:0];
      end
    endfunction

    function logic [16:0] live_count();
      return (count_reg == 16'd0) ? 17'd1 : {1'b0, count_reg};
    endfunction

    function void expect_entry(ccp_pkg::kind_e kind, logic rec, logic [15:0] first_name,
                               logic [15:0] range_left, logic last);
      charset_entry_t e;
      e.kind       = kind;
      e.is_record  = rec;
      e.first_name = first_name;
      e.range_left = range_left;
      e.last       = last;
      expected_entries.push_back(e);
    endfunction

    function void take_item(ccp_pkg::op_kind_e cmd, logic [7:0] b);
      logic [31:0] acc;
      logic [2:0]  need;
      logic [15:0] first_name;
      logic [15:0] range_left;
      logic        done;
      if (cmd == ccp_pkg::OP_START) begin
        pos       = '0;
        acc_bytes = '0;
        covered   = 17'd1;
        fmt       = '0;
        if (offset_reg <= 31'd2) begin
          phase      = PARSE_IDLE;
          names_left = '0;
          expect_entry(ccp_pkg::kind_e'(offset_reg[2:0]), 1'b0, '0, '0, 1'b1);
        end else begin
          phase      = PARSE_FORMAT;
          names_left = 16'(live_count() - 17'd1);
        end
      end else if (phase == PARSE_FORMAT) begin
        if (b > 8'd2) begin
          phase = PARSE_IDLE;
          expect_entry(ccp_pkg::KIND_UNKNOWN, 1'b0, '0, '0, 1'b1);
        end else begin
          fmt       = b[1:0];
          pos       = '0;
          acc_bytes = '0;
          if ((b == 8'd0) ? (names_left == 16'd0) : (covered >= live_count())) begin
            phase = PARSE_IDLE;
            expect_entry(ccp_pkg::kind_e'(ccp_pkg::KIND_FORMAT0 + 3'(fmt)), 1'b0, '0, '0,
                         1'b1);
          end else begin
            phase = PARSE_RECORDS;
          end
        end
      end else if (phase == PARSE_RECORDS) begin
        need = (fmt == 2'd0) ? 3'd2 : ((fmt == 2'd1) ? 3'd3 : 3'd4);
        acc  = {acc_bytes, b};
        if ({1'b0, pos} + 3'd1 < need) begin
          acc_bytes = acc[23:0];
          pos       = pos + 2'd1;
        end else begin
          pos       = '0;
          acc_bytes = '0;
          if (fmt == 2'd0) begin
            first_name = acc[15:0];
            range_left = '0;
            names_left = names_left - 16'd1;
            done       = (names_left == 16'd0);
          end else if (fmt == 2'd1) begin
            first_name = acc[23:8];
            range_left = {8'd0, acc[7:0]};
            covered    = covered + 17'd1 + {1'b0, range_left};
            done       = (covered >= live_count());
          end else begin
            first_name = acc[31:16];
            range_left = acc[15:0];
            covered    = covered + 17'd1 + {1'b0, range_left};
            done       = (covered >= live_count());
          end
          if (done) phase = PARSE_IDLE;
          expect_entry(ccp_pkg::kind_e'(ccp_pkg::KIND_FORMAT0 + 3'(fmt)), 1'b1, first_name,
                       range_left, done);
        end
      end
    endfunction

    function void check_entry(charset_entry_t got);
      charset_entry_t exp;
      if (expected_entries.size() == 0) begin
        errors++;
        $display("%0t: unexpected item kind=%0d rec=%0b first=%h left=%h last=%0b",
                 $time, got.kind, got.is_record, got.first_name, got.range_left, got.last);
      end else begin
        exp = expected_entries.pop_front();
        if (got.kind !== exp.kind || got.is_record !== exp.is_record ||
            got.first_name !== exp.first_name || got.range_left !== exp.range_left ||
            got.last !== exp.last) begin
          errors++;
          $display("%0t: expected kind=%0d rec=%0b first=%h left=%h last=%0b", $time,
                   exp.kind, exp.is_record, exp.first_name, exp.range_left, exp.last);
          $display("%0t:   actual kind=%0d rec=%0b first=%h left=%h last=%0b", $time,
                   got.kind, got.is_record, got.first_name, got.range_left, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned items_sent = 0;
  logic [30:0] cur_offset = '0;
  logic [15:0] cur_count = 16'd1;

  charset_tracker tracker = new();

  ccp_in_if  in_if ();
  ccp_out_if out_if ();
  ccp_cfg_if cfg_if ();

  cff_charset_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.command    = ccp_pkg::OP_START;
    in_if.byte_value = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = ccp_pkg::REG_CHARSET_OFFSET;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    charset_entry_t seen;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        seen.kind       = ccp_pkg::kind_e'(out_if.kind);
        seen.is_record  = out_if.is_record;
        seen.first_name = out_if.first_name;
        seen.range_left = out_if.range_left;
        seen.last       = out_if.last;
        tracker.check_entry(seen);
      end
      if (in_if.valid && in_if.ready) begin
        tracker.take_item(ccp_pkg::op_kind_e'(in_if.command), in_if.byte_value);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        tracker.write_reg(ccp_pkg::reg_idx_e'(cfg_if.index), cfg_if.data);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("cff_charset_parser: mismatch");
      $finish;
    end
  end

  task automatic send_item(input ccp_pkg::op_kind_e cmd, input logic [7:0] b,
                           input bit counted);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.byte_value <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (counted) items_sent++;
  endtask

  // drain all results, then give result-less items time to retire
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_entries.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [30:0] offset, input logic [15:0] count);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= ccp_pkg::REG_CHARSET_OFFSET;
    cfg_if.data  <= offset;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.index <= ccp_pkg::REG_GLYPH_COUNT;
    cfg_if.data  <= {15'd0, count};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_offset = offset;
    cur_count  = count;
  endtask

  task automatic run_charset();
    logic [7:0]  fmt;
    logic [7:0]  body[$];
    logic [15:0] range_left;
    int unsigned covered;
    int unsigned names;
    int unsigned cut;
    send_item(ccp_pkg::OP_START, 8'($urandom), 1'b1);
    if (cur_offset <= 31'd2) begin
      if ($urandom_range(3) == 0) send_item(ccp_pkg::OP_BYTE, 8'($urandom), 1'b0);
      return;
    end
    fmt = ($urandom_range(9) == 0) ? 8'($urandom_range(3, 255)) : 8'($urandom_range(0, 2));
    send_item(ccp_pkg::OP_BYTE, fmt, 1'b1);
    if (fmt == 8'd0) begin
      names = (cur_count == 16'd0) ? 0 : cur_count - 1;
      if (names > 40) names = 40;
      repeat (names) begin
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
      end
    end else if (fmt <= 8'd2) begin
      covered = 1;
      while (covered < cur_count && body.size() < 120) begin
        range_left = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        if (fmt == 8'd1) range_left[15:8] = '0;
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
        if (fmt == 8'd2) body.push_back(range_left[15:8]);
        body.push_back(range_left[7:0]);
        covered += range_left + 1;
      end
    end
    cut = body.size();
    if (body.size() > 0 && $urandom_range(9) == 0) cut = $urandom_range(body.size() - 1);
    for (int i = 0; i < cut; i++) send_item(ccp_pkg::OP_BYTE, body[i], 1'b1);
    if (cut == body.size() && $urandom_range(4) == 0) begin
      send_item(ccp_pkg::OP_BYTE, 8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int unsigned target;
    logic [30:0] offset;
    logic [15:0] count;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // predefined charsets, then a byte with no parse open
    configure(31'd0, 16'd1);
    send_item(ccp_pkg::OP_START, 8'h00, 1'b1);
    settle();
    configure(31'd1, 16'd65535);
    send_item(ccp_pkg::OP_START, 8'hFF, 1'b1);
    settle();
    configure(31'd2, 16'd0);
    send_item(ccp_pkg::OP_START, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'hFF, 1'b0);
    settle();
    // empty charsets, byte after the end
    configure(31'd3, 16'd1);
    send_item(ccp_pkg::OP_START, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_START, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'h01, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'hA5, 1'b0);
    settle();
    // zero glyph count, unknown format
    configure(31'h7FFF_FFFF, 16'd0);
    send_item(ccp_pkg::OP_START, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'h02, 1'b1);
    send_item(ccp_pkg::OP_START, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'hFF, 1'b1);
    settle();
    // one record of each format, with a restart mid-record
    configure(31'd200, 16'd2);
    send_item(ccp_pkg::OP_START, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'hFF, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'hFF, 1'b1);
    send_item(ccp_pkg::OP_START, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'h01, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'hFF, 1'b1);
    send_item(ccp_pkg::OP_START, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'h02, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'hAB, 1'b1);
    send_item(ccp_pkg::OP_START, 8'h00, 1'b1);
    send_item(ccp_pkg::OP_BYTE, 8'h02, 1'b1);
    repeat (4) send_item(ccp_pkg::OP_BYTE, 8'hFF, 1'b1);
    settle();

    items_sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 76;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 76;
        end
        default: begin
          src_idle_pct   = 33;
          sink_stall_pct = 33;
        end
      endcase
      for (int round = 0; round < 3; round++) begin
        settle();
        case ($urandom_range(9))
          0: offset = 31'($urandom_range(0, 2));
          1: offset = 31'd3;
          2: offset = 31'h7FFF_FFFF;
          default: offset = 31'($urandom);
        endcase
        case ($urandom_range(9))
          0: count = 16'd1;
          1: count = 16'd65535;
          2: count = 16'($urandom);
          default: count = 16'($urandom_range(2, 24));
        endcase
        configure(offset, count);
        target = items_sent + 34;
        while (items_sent < target) run_charset();
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_entries.size() == 0) begin
      $display("cff_charset_parser: match");
    end else begin
      $display("cff_charset_parser: mismatch");
    end
    $finish;
  end

endmodule
